@@ hw/rtl/msx_pkg.sv @@
// ----------------------------------------------------------------------------
// msx_pkg
// Shared types, constants and the pixel decode function for the masked
// spectral trace extraction block.
// ----------------------------------------------------------------------------
`default_nettype none

package msx_pkg;

	// Field widths of the pixel and result beats
	localparam int unsigned PIX_W         = 32;
	localparam int unsigned WEIGHT_W      = 16;
	localparam int unsigned WEIGHT_FIELDS = 4;
	localparam int unsigned SUM_W         = 64;
	localparam int unsigned BIN_OUT_W     = 12;

	// Decoded pixel is 33-bit signed, weight is zero-extended to 17 bits
	localparam int unsigned PIX_EXT_W = PIX_W + 1;
	localparam int unsigned PROD_W    = PIX_EXT_W + WEIGHT_W + 1;

	// Configuration port
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 8;
	localparam int unsigned FMT_W      = 2;
	localparam int unsigned TRACES_W   = 3;

	localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TRACES_IN_USE = 2'd1;

	// Pixel formats (code 3 reads as unsigned 16-bit)
	localparam logic [FMT_W-1:0] FMT_U16 = 2'd0;
	localparam logic [FMT_W-1:0] FMT_S16 = 2'd1;
	localparam logic [FMT_W-1:0] FMT_U32 = 2'd2;

	localparam logic [FMT_W-1:0]    FMT_RESET    = FMT_U16;
	localparam logic [TRACES_W-1:0] TRACES_RESET = 3'd4;

	// Default parameter values for the top level
	localparam int unsigned DEF_TRACE_LANES    = 4;
	localparam int unsigned DEF_BIN_INDEX_BITS = 12;

	// Per-lane pipeline control
	typedef struct packed {
		logic load;      // stage 1 -> stage 2 transfer
		logic acc_step;  // stage 2 item folds into the accumulator
		logic clear;     // stage 2 item closes the bin
	} lane_ctrl_t;

	// Interpret raw pixel bits per format
	function automatic logic signed [PIX_EXT_W-1:0] pixel_decode(
		input logic [FMT_W-1:0] fmt,
		input logic [PIX_W-1:0] raw
	);
		logic signed [PIX_EXT_W-1:0] v;
		case (fmt)
			FMT_S16: v = PIX_EXT_W'($signed(raw[15:0]));
			FMT_U32: v = $signed({1'b0, raw});
			default: v = $signed({{(PIX_EXT_W-16){1'b0}}, raw[15:0]});
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/msx_if.sv @@
// ----------------------------------------------------------------------------
// msx channel interfaces
// Pixel, result and configuration channels, each a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface msx_pix_if;
	logic        valid;
	logic        ready;
	logic [31:0] pixel_value;
	logic [15:0] mask_weight_0;
	logic [15:0] mask_weight_1;
	logic [15:0] mask_weight_2;
	logic [15:0] mask_weight_3;
	logic        bin_last;
	logic        frame_last;

	modport source (
		output valid, pixel_value, mask_weight_0, mask_weight_1,
		       mask_weight_2, mask_weight_3, bin_last, frame_last,
		input  ready
	);
	modport sink (
		input  valid, pixel_value, mask_weight_0, mask_weight_1,
		       mask_weight_2, mask_weight_3, bin_last, frame_last,
		output ready
	);
endinterface

interface msx_res_if;
	logic               valid;
	logic               ready;
	logic signed [63:0] trace_sum_0;
	logic signed [63:0] trace_sum_1;
	logic signed [63:0] trace_sum_2;
	logic signed [63:0] trace_sum_3;
	logic [11:0]        bin_number;
	logic               frame_done;

	modport source (
		output valid, trace_sum_0, trace_sum_1, trace_sum_2, trace_sum_3,
		       bin_number, frame_done,
		input  ready
	);
	modport sink (
		input  valid, trace_sum_0, trace_sum_1, trace_sum_2, trace_sum_3,
		       bin_number, frame_done,
		output ready
	);
endinterface

interface msx_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [7:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/masked_spectral_trace_extract_unit.sv @@
// ----------------------------------------------------------------------------
// masked_spectral_trace_extract_unit
// Weighted mask spectral extraction: per-lane multiply-accumulate of pixels
// by mask weights, one result beat per closed spectral bin.
// ----------------------------------------------------------------------------
// The block takes one pixel beat every clock cycle and sustains that rate
// indefinitely while the result sink keeps up. A pixel passes an input
// register, a product register per lane (one 33x17 multiply each) and then
// the saturating accumulate, whose closing beat lands in the result register.
// Pixels that do not close a bin give no result beat. The pipeline stalls
// only while the result register holds an untaken beat. There is no start-up
// clearing pass; the block accepts pixels straight out of reset.
// Configuration must be written while no pixel is in flight.
`default_nettype none

module masked_spectral_trace_extract_unit #(
	parameter int unsigned TRACE_LANES    = msx_pkg::DEF_TRACE_LANES,
	parameter int unsigned BIN_INDEX_BITS = msx_pkg::DEF_BIN_INDEX_BITS
) (
	input  wire logic clk,
	input  wire logic arst_n,
	msx_pix_if.sink   pix,
	msx_res_if.source res,
	msx_cfg_if.sink   cfg
);
	import msx_pkg::*;

	localparam int unsigned NUM_LANES =
		(TRACE_LANES < WEIGHT_FIELDS) ? TRACE_LANES : WEIGHT_FIELDS;

	logic [FMT_W-1:0]    fmt;
	logic [TRACES_W-1:0] traces;

	logic                      adv;
	logic                      valid_s1;
	logic                      valid_s2;
	logic [PIX_W-1:0]          pix_raw_s1;
	logic signed [PIX_EXT_W-1:0] pix_dec;
	logic                      blast_s1, flast_s1;
	logic                      close_s2, flast_s2;
	logic                      bin_fire;
	logic [BIN_INDEX_BITS-1:0] bin_cnt_q;
	lane_ctrl_t                lane_ctrl;

	logic [WEIGHT_W-1:0]     weight_in [WEIGHT_FIELDS];
	logic signed [SUM_W-1:0] sum_next  [WEIGHT_FIELDS];

	logic                    res_valid_q;
	logic signed [SUM_W-1:0] res_sum_q [WEIGHT_FIELDS];
	logic [BIN_OUT_W-1:0]    res_bin_q;
	logic                    res_done_q;

	// Configuration registers
	msx_cfg_regs u_cfg (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.pixel_format  (fmt),
		.traces_in_use (traces)
	);

	// Whole pipeline moves unless a result beat is stuck
	assign adv       = !res_valid_q || res.ready;
	assign pix.ready = adv;
	assign bin_fire  = adv && valid_s2 && close_s2;

	// Pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= pix.valid;
			valid_s2 <= valid_s1;
		end
	end

	// Stage 1 pixel and flags
	always_ff @(posedge clk) begin
		if (adv) begin
			pix_raw_s1 <= pix.pixel_value;
			blast_s1   <= pix.bin_last;
			flast_s1   <= pix.frame_last;
			close_s2   <= blast_s1 || flast_s1;
			flast_s2   <= flast_s1;
		end
	end

	assign pix_dec = pixel_decode(fmt, pix_raw_s1);

	// Lane control
	always_comb begin
		lane_ctrl.load     = adv;
		lane_ctrl.acc_step = adv && valid_s2;
		lane_ctrl.clear    = close_s2;
	end

	assign weight_in[0] = pix.mask_weight_0;
	assign weight_in[1] = pix.mask_weight_1;
	assign weight_in[2] = pix.mask_weight_2;
	assign weight_in[3] = pix.mask_weight_3;

	// Trace lanes; fields past the built lanes report zero
	for (genvar k = 0; k < WEIGHT_FIELDS; k++) begin : g_lane
		if (k < NUM_LANES) begin : g_on
			msx_lane_mac u_mac (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctrl     (lane_ctrl),
				.lane_on  (TRACES_W'(k) < traces),
				.pix_s1   (pix_dec),
				.weight   (weight_in[k]),
				.lane_sum (sum_next[k])
			);
		end else begin : g_off
			assign sum_next[k] = '0;
		end
	end

	// Bin counter; frame end returns it to zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_cnt_q <= '0;
		end else if (bin_fire) begin
			bin_cnt_q <= flast_s2 ? '0 : bin_cnt_q + 1'b1;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= valid_s2 && close_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (bin_fire) begin
			for (int i = 0; i < WEIGHT_FIELDS; i++) begin
				res_sum_q[i] <= sum_next[i];
			end
			res_bin_q  <= BIN_OUT_W'(bin_cnt_q);
			res_done_q <= flast_s2;
		end
	end

	assign res.valid       = res_valid_q;
	assign res.trace_sum_0 = res_sum_q[0];
	assign res.trace_sum_1 = res_sum_q[1];
	assign res.trace_sum_2 = res_sum_q[2];
	assign res.trace_sum_3 = res_sum_q[3];
	assign res.bin_number  = res_bin_q;
	assign res.frame_done  = res_done_q;

	// A closing beat in stage 2 always lands in the result register
	a_close_emits: assert property (@(posedge clk) disable iff (!arst_n)
		bin_fire |=> res_valid_q)
		else $error("closing beat did not produce a result");

	// Frame end restarts bin numbering
	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(bin_fire && flast_s2) |=> (bin_cnt_q == '0))
		else $error("bin counter not cleared after frame end");

	// With no lane in use, sums 0 and 3 read zero
	a_idle_lanes_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && traces == '0) |-> (res_sum_q[0] == '0 && res_sum_q[3] == '0))
		else $error("inactive lane reported a nonzero sum");

endmodule

`default_nettype wire

@@ hw/rtl/msx_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// msx_cfg_regs
// Configuration registers: pixel format and number of active trace lanes.
// ----------------------------------------------------------------------------
`default_nettype none

module msx_cfg_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	msx_cfg_if.sink                            cfg,
	output logic [msx_pkg::FMT_W-1:0]          pixel_format,
	output logic [msx_pkg::TRACES_W-1:0]       traces_in_use
);
	import msx_pkg::*;

	logic [FMT_W-1:0]    fmt_q;
	logic [TRACES_W-1:0] traces_q;

	// Writes are always taken
	assign cfg.ready = 1'b1;

	// Register file; indexes off the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q    <= FMT_RESET;
			traces_q <= TRACES_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_PIXEL_FORMAT:  fmt_q    <= cfg.data[FMT_W-1:0];
				REG_TRACES_IN_USE: traces_q <= cfg.data[TRACES_W-1:0];
				default: ;
			endcase
		end
	end

	assign pixel_format  = fmt_q;
	assign traces_in_use = traces_q;

endmodule

`default_nettype wire

@@ hw/rtl/msx_lane_mac.sv @@
// ----------------------------------------------------------------------------
// msx_lane_mac
// One trace lane: weight register, registered product and a saturating
// 64-bit accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module msx_lane_mac (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire msx_pkg::lane_ctrl_t                   ctrl,
	input  wire logic                                  lane_on,
	input  wire logic signed [msx_pkg::PIX_EXT_W-1:0]  pix_s1,
	input  wire logic [msx_pkg::WEIGHT_W-1:0]          weight,
	output logic signed [msx_pkg::SUM_W-1:0]           lane_sum
);
	import msx_pkg::*;

	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	logic [WEIGHT_W-1:0]      weight_s1;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [SUM_W-1:0]  acc_q;
	logic signed [SUM_W-1:0]  prod_ext;
	logic signed [SUM_W-1:0]  raw_sum;
	logic signed [SUM_W-1:0]  sat_sum;
	logic                     ovf;

	// Weight rides alongside the pixel in stage 1
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			weight_s1 <= weight;
		end
	end

	// Stage 2 product: 33-bit signed pixel times 17-bit non-negative weight
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			prod_s2 <= PROD_W'(pix_s1 * $signed({1'b0, weight_s1}));
		end
	end

	// Saturating add
	always_comb begin
		prod_ext = {{(SUM_W-PROD_W){prod_s2[PROD_W-1]}}, prod_s2};
		raw_sum  = acc_q + prod_ext;
		ovf      = (acc_q[SUM_W-1] == prod_ext[SUM_W-1]) &&
		           (raw_sum[SUM_W-1] != acc_q[SUM_W-1]);
		sat_sum  = ovf ? (acc_q[SUM_W-1] ? SUM_MIN : SUM_MAX) : raw_sum;
	end

	// Accumulator; cleared when the bin closes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctrl.acc_step) begin
			if (ctrl.clear) begin
				acc_q <= '0;
			end else if (lane_on) begin
				acc_q <= sat_sum;
			end
		end
	end

	// Sum including the closing beat; idle lanes report zero
	assign lane_sum = lane_on ? sat_sum : '0;

endmodule

`default_nettype wire
